// ===== design/bnc_pkg.sv =====
package bnc_pkg;

    // Stack size and derived widths
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SCORE_W     = 38;
    localparam int PEN_W       = 16;
    localparam int NUM_REGS    = 4;
    localparam int ADDR_W      = $clog2(NUM_REGS) + 2;
    localparam int DATA_W      = 32;

    // Register reset values
    localparam logic [PEN_W-1:0] PEN_PAREN_RST  = 16'd3;
    localparam logic [PEN_W-1:0] PEN_SQUARE_RST = 16'd57;
    localparam logic [PEN_W-1:0] PEN_CURLY_RST  = 16'd1197;
    localparam logic [PEN_W-1:0] PEN_ANGLE_RST  = 16'd25137;

    // Register indexes
    localparam logic [1:0] REG_PAREN  = 2'd0;
    localparam logic [1:0] REG_SQUARE = 2'd1;
    localparam logic [1:0] REG_CURLY  = 2'd2;
    localparam logic [1:0] REG_ANGLE  = 2'd3;

    // Line status codes
    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_CORRUPTED  = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    // Bracket kinds
    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } char_item_t;

    typedef struct packed {
        logic [1:0]         line_status;
        logic [SCORE_W-1:0] line_score;
    } res_item_t;

    typedef logic [NUM_REGS-1:0][PEN_W-1:0] pen_set_t;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
    } bracket_t;

    typedef enum logic [1:0] {
        S_RUN,
        S_WALK,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic walk;
        logic emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dp_sts_t;

    // Classify one character
    function automatic bracket_t decode_char(input logic [7:0] c);
        bracket_t b;
        b = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        case (c)
            8'h28: b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
            8'h5B: b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
            8'h7B: b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
            8'h3C: b = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
            8'h29: b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
            8'h5D: b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
            8'h7D: b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
            8'h3E: b = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
            default: b = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        endcase
        return b;
    endfunction

endpackage

// ===== design/bnc_regs.sv =====
module bnc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bnc_pkg::ADDR_W-1:0] paddr,
    input  logic [bnc_pkg::DATA_W-1:0] pwdata,
    output logic [bnc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output bnc_pkg::pen_set_t         penalty
);
    import bnc_pkg::*;

    pen_set_t   pen_reg;
    pen_set_t   pen_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register write
    always_comb
    begin
        pen_next = pen_reg;
        if (wr_en)
        begin
            pen_next[idx] = pwdata[PEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg[REG_PAREN]  <= PEN_PAREN_RST;
            pen_reg[REG_SQUARE] <= PEN_SQUARE_RST;
            pen_reg[REG_CURLY]  <= PEN_CURLY_RST;
            pen_reg[REG_ANGLE]  <= PEN_ANGLE_RST;
        end
        else
        begin
            pen_reg <= pen_next;
        end
    end

    // Read back, zero-extended
    assign prdata  = DATA_W'(pen_reg[idx]);
    assign penalty = pen_reg;

endmodule

// ===== design/bnc_ctrl.sv =====
module bnc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    input  logic              line_end,
    output logic              char_stall,
    input  bnc_pkg::dp_sts_t  sts,
    output bnc_pkg::dp_cmd_t  cmd
);
    import bnc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign take = char_valid && (state_reg == S_RUN);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_RUN:
            begin
                if (take && line_end)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_RUN;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Outputs
    always_comb
    begin
        char_stall = 1'b1;
        cmd        = '0;
        case (state_reg)
            S_RUN:
            begin
                char_stall = 1'b0;
                cmd.take   = char_valid;
            end
            S_WALK:
            begin
                cmd.walk = !sts.walk_done;
            end
            S_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                char_stall = 1'b1;
            end
        endcase
    end

`ifndef SYNTH
    // A line end always leads into the score walk
    a_line_end_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && line_end |=> state_reg == S_WALK)
        else $error("line end did not start the walk");

    // Walk and result load never overlap a new transaction
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk || cmd.emit) |-> !cmd.take)
        else $error("character taken during end of line");

    // The walk ends in the result state
    a_walk_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK && sts.walk_done |=> state_reg == S_EMIT)
        else $error("walk finished without result");
`endif

endmodule

// ===== design/bnc_dp.sv =====
module bnc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  bnc_pkg::char_item_t char_data,
    input  bnc_pkg::pen_set_t   penalty,
    input  bnc_pkg::dp_cmd_t    cmd,
    output bnc_pkg::dp_sts_t    sts,
    output logic                res_valid,
    input  logic                res_stall,
    output bnc_pkg::res_item_t  res_data
);
    import bnc_pkg::*;

    // Stack as a shift line, entry 0 is the top
    logic [STACK_DEPTH-1:0][1:0] stack_reg;
    logic [STACK_DEPTH-1:0][1:0] stack_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        corr_reg;
    logic                        corr_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic                        incomp_reg;
    logic                        incomp_next;
    logic [PEN_W-1:0]            held_pen_reg;
    logic [PEN_W-1:0]            held_pen_next;
    logic [SCORE_W-1:0]          score_reg;
    logic [SCORE_W-1:0]          score_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    res_item_t                   res_data_reg;
    res_item_t                   res_data_next;

    bracket_t                    br;
    logic                        do_push;
    logic                        do_pop;
    logic                        full;
    logic                        empty;
    logic                        line_dead;
    logic [1:0]                  status;

    assign br        = decode_char(char_data.char_code);
    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign line_dead = corr_reg || ovf_reg;

    // Character handling and walk control
    always_comb
    begin
        do_push       = 1'b0;
        do_pop        = 1'b0;
        corr_next     = corr_reg;
        ovf_next      = ovf_reg;
        held_pen_next = held_pen_reg;
        incomp_next   = incomp_reg;
        score_next    = score_reg;
        if (cmd.take && !line_dead)
        begin
            if (br.is_open)
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            else if (br.is_close)
            begin
                if (!empty && stack_reg[0] == br.kind)
                begin
                    do_pop = 1'b1;
                end
                else
                begin
                    corr_next     = 1'b1;
                    held_pen_next = penalty[br.kind];
                end
            end
        end
        // Completion score: score*5 + value, one open bracket a cycle
        if (cmd.walk)
        begin
            do_pop      = 1'b1;
            incomp_next = 1'b1;
            score_next  = (score_reg << 2) + score_reg
                          + SCORE_W'(stack_reg[0]) + SCORE_W'(1);
        end
        if (cmd.emit)
        begin
            corr_next     = 1'b0;
            ovf_next      = 1'b0;
            incomp_next   = 1'b0;
            held_pen_next = '0;
            score_next    = '0;
        end
    end

    // Stack shift and depth count
    always_comb
    begin
        stack_next = stack_reg;
        count_next = count_reg;
        if (do_push)
        begin
            for (int i = 1; i < STACK_DEPTH; i++)
            begin
                stack_next[i] = stack_reg[i-1];
            end
            stack_next[0] = br.kind;
            count_next    = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                stack_next[i] = stack_reg[i+1];
            end
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.emit)
        begin
            count_next = '0;
        end
    end

    // Result status
    always_comb
    begin
        if (ovf_reg)
        begin
            status = ST_OVERFLOW;
        end
        else if (corr_reg)
        begin
            status = ST_CORRUPTED;
        end
        else if (incomp_reg)
        begin
            status = ST_INCOMPLETE;
        end
        else
        begin
            status = ST_COMPLETE;
        end
    end

    assign sts.walk_done = line_dead || empty;
    assign sts.out_free  = !res_valid_reg || !res_stall;

    // Output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            res_valid_next           = 1'b1;
            res_data_next.line_status = status;
            case (status)
                ST_CORRUPTED:  res_data_next.line_score = SCORE_W'(held_pen_reg);
                ST_INCOMPLETE: res_data_next.line_score = score_reg;
                default:       res_data_next.line_score = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            corr_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            incomp_reg    <= 1'b0;
            held_pen_reg  <= '0;
            score_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            corr_reg      <= corr_next;
            ovf_reg       <= ovf_next;
            incomp_reg    <= incomp_next;
            held_pen_reg  <= held_pen_next;
            score_reg     <= score_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        stack_reg    <= stack_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef SYNTH
    // Depth never exceeds the stack
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth out of range");

    // Walk only pops real entries of a live line
    a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> !empty && !line_dead)
        else $error("walk on empty or dead line");

    // Line state is clean after a result is loaded
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> count_reg == '0 && !corr_reg && !ovf_reg && score_reg == '0)
        else $error("line state not cleared");

    // Complete and overflowed lines carry a zero score
    a_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_data_reg.line_status == ST_COMPLETE
                          || res_data_reg.line_status == ST_OVERFLOW)
        |-> res_data_reg.line_score == '0)
        else $error("nonzero score on complete or overflow");
`endif

endmodule

// ===== design/bracket_nesting_checker_core.sv =====
// Bracket nesting checker: takes one ASCII character per transaction on the
// char channel and checks nesting of (), [], {} and <> with a 16-entry stack
// of opener kinds. For a character flagged as line end on a line that is
// neither corrupted nor overflowed, the completion score is built by
// popping the stack shift line one entry per cycle (score = score*5 +
// value); a corrupted or overflowed line skips this walk. Then the result
// is loaded into the output register. While a result waits there the block
// goes on taking characters; a second line end waits only if the first
// result has not been taken.
// Penalties for a bad closer are set over the APB port at byte addresses
// 0, 4, 8 and 12 (round, square, curly, angle).
module bracket_nesting_checker_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  bnc_pkg::char_item_t        char_data,
    output logic                       res_valid,
    input  logic                       res_stall,
    output bnc_pkg::res_item_t         res_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bnc_pkg::ADDR_W-1:0] paddr,
    input  logic [bnc_pkg::DATA_W-1:0] pwdata,
    output logic [bnc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bnc_pkg::*;

    pen_set_t penalty;
    dp_cmd_t  cmd;
    dp_sts_t  sts;

    bnc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .penalty (penalty)
    );

    bnc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .line_end   (char_data.line_end),
        .char_stall (char_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    bnc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_data (char_data),
        .penalty   (penalty),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
